### sv/tfd_pkg.sv
// Package for the torsion fingerprint deviation block: constants, types and
// controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps
package tfd_pkg;
	localparam int MAX_QUARTETS_DEF = 8;
	localparam logic [14:0] FULL_TURN = 15'd23040;
	localparam logic [14:0] HALF_TURN = 15'd11520;
	localparam logic [1:0] KIND_SINGLE = 2'd0;
	localparam logic [1:0] KIND_RING = 2'd1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_SCAN, ST_DIVDEV, ST_MUL, ST_ACC, ST_DIVOUT, ST_OUT
	} state_t;

	typedef struct packed {
		logic store;     // store accepted quartet
		logic scan_clr;  // start cross-pair scan
		logic scan_step; // advance scan one pair
		logic div_start_dev;
		logic div_start_out;
		logic mul;
		logic acc;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic div_done;
		logic lastq;
		logic lastt;
	} sts_t;

	function automatic logic [14:0] fold_angle(input logic [14:0] a);
		logic [14:0] r;
		r = (a >= FULL_TURN) ? a - FULL_TURN : a;
		return (r <= HALF_TURN) ? r : FULL_TURN - r;
	endfunction

	function automatic logic [14:0] circ_diff(input logic [14:0] a, input logic [14:0] b);
		logic [14:0] d;
		d = (a > b) ? a - b : b - a;
		if (d >= FULL_TURN) d = d - FULL_TURN;
		if (d > HALF_TURN) d = FULL_TURN - d;
		return d;
	endfunction
endpackage

### sv/tfd_if.sv
// Valid/ready channel interface with generic payload type.
// Depends on nothing.
`timescale 1ns / 1ps
interface tfd_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### sv/tfd_ram.sv
// Generic single-write, registered-read RAM.
// Depends on nothing.
`timescale 1ns / 1ps
module tfd_ram #(
	parameter int WIDTH = 15,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule

### sv/tfd_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on nothing.
`timescale 1ns / 1ps
module tfd_div #(
	parameter int NW = 40,
	parameter int DW = 28
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quot
);
	localparam int CW = $clog2(NW + 1);
	logic [DW:0]   rem_q;
	logic [DW-1:0] den_q;
	logic [NW-1:0] quot_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;

	always_comb trial = {rem_q[DW-1:0], quot_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quot_q <= num;
		end else if (busy_q) begin
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quot_q <= {quot_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quot_q <= {quot_q[NW-2:0], 1'b0};
			end
		end
	end
	assign quot = quot_q;
endmodule

### sv/tfd_ctrl.sv
// Controller state machine of the deviation block.
// Depends on tfd_pkg.
`timescale 1ns / 1ps
module tfd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  tfd_pkg::sts_t   sts,
	output tfd_pkg::cmd_t   cmd
);
	tfd_pkg::state_t st_q, st_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= tfd_pkg::ST_IDLE;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			tfd_pkg::ST_IDLE: if (in_valid && sts.lastq) st_d = tfd_pkg::ST_SCAN;
			tfd_pkg::ST_SCAN: if (sts.scan_done) st_d = tfd_pkg::ST_DIVDEV;
			tfd_pkg::ST_DIVDEV: if (sts.div_done) st_d = tfd_pkg::ST_MUL;
			tfd_pkg::ST_MUL: st_d = tfd_pkg::ST_ACC;
			tfd_pkg::ST_ACC: st_d = sts.lastt ? tfd_pkg::ST_DIVOUT : tfd_pkg::ST_IDLE;
			tfd_pkg::ST_DIVOUT: if (sts.div_done) st_d = tfd_pkg::ST_OUT;
			tfd_pkg::ST_OUT: if (out_ready) st_d = tfd_pkg::ST_IDLE;
			default: st_d = tfd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = (st_q == tfd_pkg::ST_IDLE);
		out_valid = (st_q == tfd_pkg::ST_OUT);
		cmd.store = in_ready && in_valid;
		cmd.scan_clr = cmd.store && sts.lastq;
		cmd.scan_step = (st_q == tfd_pkg::ST_SCAN);
		cmd.div_start_dev = (st_q == tfd_pkg::ST_SCAN) && sts.scan_done;
		cmd.mul = (st_q == tfd_pkg::ST_MUL);
		cmd.acc = (st_q == tfd_pkg::ST_ACC);
		cmd.div_start_out = (st_q == tfd_pkg::ST_ACC) && sts.lastt;
		cmd.out_load = (st_q == tfd_pkg::ST_DIVOUT) && sts.div_done;
	end
endmodule

### sv/tfd_dp.sv
// Datapath: angle stores, ring sums, cross-pair scan, divider, accumulators.
// Depends on tfd_pkg, tfd_ram, tfd_div.
`timescale 1ns / 1ps
module tfd_dp #(
	parameter int MAX_QUARTETS = tfd_pkg::MAX_QUARTETS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  tfd_pkg::cmd_t cmd,
	output tfd_pkg::sts_t sts,
	input  logic [14:0]   angle_first,
	input  logic [14:0]   angle_second,
	input  logic [1:0]    torsion_kind,
	input  logic [14:0]   max_dev,
	input  logic [15:0]   weight,
	input  logic          last_quartet,
	input  logic          last_torsion,
	output logic [15:0]   deviation_value,
	output logic          weights_were_zero
);
	localparam int AW = (MAX_QUARTETS > 1) ? $clog2(MAX_QUARTETS) : 1;
	localparam int CW = $clog2(MAX_QUARTETS + 1);
	localparam int SW = 15 + CW;
	localparam logic [39:0] WSUM_MAX = '1;
	localparam logic [27:0] WGT_MAX = '1;

	logic [CW-1:0] qcnt_q;
	logic [17:0]   rsum_a_q, rsum_b_q;
	logic [1:0]    kind_q;
	logic [14:0]   mdev_q;
	logic [15:0]   wgt_q;
	logic          lastt_q;
	logic [CW-1:0] n_q;
	logic          full;
	logic [AW-1:0] wa, ra, rb;

	assign full = (qcnt_q >= CW'(MAX_QUARTETS));
	assign wa = qcnt_q[AW-1:0];

	// scan indices: i over first store, j over second store
	logic [CW-1:0] i_q, j_q;
	logic          scan_q, pend_q, scan_done_q;
	logic [14:0]   ra_d, rb_d, best_q, cd;
	assign ra = i_q[AW-1:0];
	assign rb = j_q[AW-1:0];

	tfd_ram #(.WIDTH(15), .DEPTH(1 << AW)) u_ram_a (
		.clk(clk), .we(cmd.store && !full), .waddr(wa), .wdata(angle_first),
		.raddr(ra), .rdata(ra_d));
	tfd_ram #(.WIDTH(15), .DEPTH(1 << AW)) u_ram_b (
		.clk(clk), .we(cmd.store && !full), .waddr(wa), .wdata(angle_second),
		.raddr(rb), .rdata(rb_d));

	assign cd = tfd_pkg::circ_diff(ra_d, rb_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
			rsum_a_q <= '0;
			rsum_b_q <= '0;
		end else if (cmd.store) begin
			if (last_quartet) begin
				qcnt_q <= '0;
				rsum_a_q <= '0;
				rsum_b_q <= '0;
			end else if (!full) begin
				qcnt_q <= qcnt_q + 1'b1;
				rsum_a_q <= rsum_a_q + 18'(tfd_pkg::fold_angle(angle_first));
				rsum_b_q <= rsum_b_q + 18'(tfd_pkg::fold_angle(angle_second));
			end
		end
	end

	// closing-item latch; ring sums include the closing quartet when stored
	logic [17:0] fa_s, fb_s;
	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			kind_q <= torsion_kind;
			mdev_q <= (max_dev == '0) ? 15'd1 : max_dev;
			wgt_q <= weight;
			lastt_q <= last_torsion;
			n_q <= full ? qcnt_q : qcnt_q + 1'b1;
			fa_s <= full ? rsum_a_q : rsum_a_q + 18'(tfd_pkg::fold_angle(angle_first));
			fb_s <= full ? rsum_b_q : rsum_b_q + 18'(tfd_pkg::fold_angle(angle_second));
		end
	end

	// scan: single reads pair (0,0) only; ring needs no reads
	logic          one_pair;
	assign one_pair = (kind_q == tfd_pkg::KIND_SINGLE);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= 1'b0;
			pend_q <= 1'b0;
			scan_done_q <= 1'b0;
		end else begin
			scan_done_q <= 1'b0;
			if (cmd.scan_clr) begin
				scan_q <= 1'b1;
				pend_q <= 1'b0;
			end else if (cmd.scan_step) begin
				pend_q <= scan_q;
				if (scan_q && (one_pair || kind_q == tfd_pkg::KIND_RING ||
						(i_q == n_q - 1'b1 && j_q == n_q - 1'b1)))
					scan_q <= 1'b0;
				if (!scan_q && pend_q) scan_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_clr) begin
			i_q <= '0;
			j_q <= '0;
			best_q <= tfd_pkg::HALF_TURN;
		end else if (cmd.scan_step) begin
			if (scan_q) begin
				if (j_q == n_q - 1'b1) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else j_q <= j_q + 1'b1;
			end
			if (pend_q) begin
				if (one_pair) best_q <= cd;
				else if (cd < best_q) best_q <= cd;
			end
		end
	end

	assign sts.scan_done = scan_done_q && cmd.scan_step;
	assign sts.lastq = last_quartet;
	assign sts.lastt = lastt_q;

	// divider operands
	logic [17:0]   rdiff;
	logic [31:0]   dev_num;
	logic [SW-1:0] den_dev;
	logic [39:0]   dnum;
	logic [27:0]   dden;
	logic [39:0]   quot;
	logic          ddone;
	logic          out_phase_q;
	logic [39:0]   wsum_q;
	logic [27:0]   wgt_sum_q;

	assign rdiff = (fa_s > fb_s) ? fa_s - fb_s : fb_s - fa_s;
	assign den_dev = (kind_q == tfd_pkg::KIND_RING) ? SW'(n_q) * SW'(mdev_q) : SW'(mdev_q);
	assign dev_num = (kind_q == tfd_pkg::KIND_RING) ? {rdiff, 14'd0} : {3'd0, best_q, 14'd0};

	tfd_div #(.NW(40), .DW(28)) u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start_dev || cmd.div_start_out),
		.num(dnum), .den(dden), .done(ddone), .quot(quot));
	assign sts.div_done = ddone;

	logic [15:0] dev_s;
	logic [31:0] prod_q;
	always_ff @(posedge clk) begin
		if (ddone) dev_s <= (quot > 40'hFFFF) ? 16'hFFFF : quot[15:0];
		if (cmd.mul) prod_q <= dev_s * wgt_q;
	end

	logic [40:0] wsum_n;
	logic [28:0] wgt_n;
	logic [39:0] wsum_sat;
	logic [27:0] wgt_sat;
	assign wsum_n = {1'b0, wsum_q} + 41'(prod_q);
	assign wgt_n = {1'b0, wgt_sum_q} + 29'(wgt_q);
	assign wsum_sat = wsum_n[40] ? WSUM_MAX : wsum_n[39:0];
	assign wgt_sat = wgt_n[28] ? WGT_MAX : wgt_n[27:0];

	// the mean divide starts on the accumulate cycle, so feed it the updated sums
	assign dnum = cmd.div_start_out ? wsum_sat : {8'd0, dev_num};
	assign dden = cmd.div_start_out ? wgt_sat : 28'(den_dev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsum_q <= '0;
			wgt_sum_q <= '0;
			out_phase_q <= 1'b0;
		end else if (cmd.acc) begin
			wsum_q <= wsum_sat;
			wgt_sum_q <= wgt_sat;
			out_phase_q <= lastt_q;
		end else if (cmd.out_load) begin
			wsum_q <= '0;
			wgt_sum_q <= '0;
			out_phase_q <= 1'b0;
		end
	end

	// output register; zero weight sum divides to all ones, forced to 0
	always_ff @(posedge clk) begin
		if (cmd.out_load && out_phase_q) begin
			weights_were_zero <= (wgt_sum_q == '0);
			deviation_value <= (wgt_sum_q == '0) ? 16'd0 :
				((quot > 40'hFFFF) ? 16'hFFFF : quot[15:0]);
		end
	end
endmodule

### sv/torsion_fingerprint_deviation.sv
// Torsion fingerprint deviation: top level.
// One input channel of quartet angle pairs, one output channel of results.
// Quartet items stream in on in_ch; items without last_quartet are accepted
// back to back (folded sums and angle stores updated on acceptance).
// The item carrying last_quartet closes a torsion: the controller then scans
// the stored angles (all cross pairs for a symmetric torsion, only pair (0,0)
// for single), runs a bit-serial divide for the normalized deviation, and
// multiplies by the weight and accumulates before in_ch is ready again.
// If last_torsion was set, a second divide gives the weighted mean, which is
// held on out_ch until the receiver takes it; in_ch stays stalled meanwhile.
// The shared divider and the angle RAM read port set the rate.
// Reset (arst_n low) clears counters, sums and the controller; the angle
// stores stay undefined until written and are only read where written.
`timescale 1ns / 1ps
module torsion_fingerprint_deviation #(
	parameter int MAX_QUARTETS = tfd_pkg::MAX_QUARTETS_DEF
) (
	input logic clk,
	input logic arst_n,
	tfd_if.sink   in_ch,
	tfd_if.source out_ch
);
	tfd_pkg::cmd_t cmd;
	tfd_pkg::sts_t sts;

	// control: sequence the torsion close and result handshake
	tfd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.sts(sts), .cmd(cmd));

	// datapath: storage, scan, divide, accumulate
	tfd_dp #(.MAX_QUARTETS(MAX_QUARTETS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.angle_first(in_ch.data.angle_first),
		.angle_second(in_ch.data.angle_second),
		.torsion_kind(in_ch.data.torsion_kind),
		.max_dev(in_ch.data.max_dev),
		.weight(in_ch.data.weight),
		.last_quartet(in_ch.data.last_quartet),
		.last_torsion(in_ch.data.last_torsion),
		.deviation_value(out_ch.data.deviation_value),
		.weights_were_zero(out_ch.data.weights_were_zero));
endmodule

### sim/torsion_fingerprint_deviation_tb.sv
// Testbench for torsion_fingerprint_deviation: drives quartet items with random
// gaps, predicts each weighted mean deviation and checks the results in order.
// Depends on tfd_pkg, tfd_if and the torsion_fingerprint_deviation RTL.
`timescale 1ns / 1ps
module torsion_fingerprint_deviation_tb;
	localparam int QMAX = tfd_pkg::MAX_QUARTETS_DEF;
	localparam int unsigned TURN = 23040;
	localparam int unsigned HALF = 11520;
	localparam logic [1:0] KIND_SYM = 2'd2;
	localparam logic [1:0] KIND_ODD = 2'd3;
	localparam longint unsigned WSUM_CAP = (64'd1 << 40) - 1;
	localparam longint unsigned WGT_CAP = (64'd1 << 28) - 1;
	localparam int STALL_LIMIT = 40000;
	localparam int HOLD_CYCLES = 3000;

	typedef struct packed {
		logic [14:0] angle_first;
		logic [14:0] angle_second;
		logic [1:0]  torsion_kind;
		logic [14:0] max_dev;
		logic [15:0] weight;
		logic        last_quartet;
		logic        last_torsion;
	} quartet_t;

	typedef struct packed {
		logic [15:0] deviation_value;
		logic        weights_were_zero;
	} tfd_result_t;

	logic clk;
	logic arst_n;

	tfd_if #(.payload_t(quartet_t))    in_ch ();
	tfd_if #(.payload_t(tfd_result_t)) out_ch ();

	torsion_fingerprint_deviation uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Mirror of the block state, updated on every accepted item
	int unsigned       mir_first [QMAX];
	int unsigned       mir_second [QMAX];
	int unsigned       mir_count;
	int unsigned       mir_ring_first;
	int unsigned       mir_ring_second;
	longint unsigned   mir_wdev_sum;
	longint unsigned   mir_wgt_sum;

	quartet_t    quartets_to_send [$];
	tfd_result_t means_due [$];

	int unsigned quartets_in;
	int unsigned means_out;
	int unsigned zero_weight_means;
	int unsigned mismatches;
	int unsigned quiet_cycles;
	logic        in_taken;
	int unsigned send_gap;
	int unsigned take_gap;
	bit          no_idle_phase;
	bit          hold_done;
	bit          hold_active;
	int unsigned hold_left;

	// Clock: 8 ns period
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int unsigned wrap_diff(int unsigned a, int unsigned b);
		int unsigned d;
		d = (a > b) ? a - b : b - a;
		if (d >= TURN) d = d - TURN;
		if (d > HALF) d = TURN - d;
		return d;
	endfunction

	function automatic int unsigned fold(int unsigned a);
		int unsigned r;
		r = (a >= TURN) ? a - TURN : a;
		return (r <= HALF) ? r : TURN - r;
	endfunction

	function automatic longint unsigned scaled_dev(longint unsigned diff, longint unsigned div);
		longint unsigned q;
		q = (diff << 14) / div;
		return (q > 64'hFFFF) ? 64'hFFFF : q;
	endfunction

	// Advance the mirror by one accepted item; queue a mean when a pair closes
	task automatic track_quartet(input quartet_t q);
		int unsigned     mdev;
		int unsigned     best;
		int unsigned     d;
		longint unsigned dev;
		longint unsigned mean;
		tfd_result_t     r;
		if (mir_count < QMAX) begin
			mir_first[mir_count]  = q.angle_first;
			mir_second[mir_count] = q.angle_second;
			mir_ring_first  += fold(q.angle_first);
			mir_ring_second += fold(q.angle_second);
			mir_count++;
		end
		if (!q.last_quartet) return;
		mdev = (q.max_dev == 0) ? 1 : q.max_dev;
		if (q.torsion_kind == tfd_pkg::KIND_SINGLE) begin
			dev = scaled_dev(wrap_diff(mir_first[0], mir_second[0]), mdev);
		end else if (q.torsion_kind == tfd_pkg::KIND_RING) begin
			d = (mir_ring_first > mir_ring_second) ? mir_ring_first - mir_ring_second
				: mir_ring_second - mir_ring_first;
			dev = scaled_dev(d, longint'(mir_count) * mdev);
		end else begin
			// symmetric and kind three: least difference over all cross pairs
			best = HALF;
			for (int i = 0; i < mir_count; i++)
				for (int j = 0; j < mir_count; j++) begin
					d = wrap_diff(mir_first[i], mir_second[j]);
					if (d < best) best = d;
				end
			dev = scaled_dev(best, mdev);
		end
		mir_wdev_sum += dev * q.weight;
		if (mir_wdev_sum > WSUM_CAP) mir_wdev_sum = WSUM_CAP;
		mir_wgt_sum += q.weight;
		if (mir_wgt_sum > WGT_CAP) mir_wgt_sum = WGT_CAP;
		mir_count = 0;
		mir_ring_first = 0;
		mir_ring_second = 0;
		if (!q.last_torsion) return;
		if (mir_wgt_sum == 0) begin
			r.deviation_value = '0;
			r.weights_were_zero = 1'b1;
		end else begin
			mean = mir_wdev_sum / mir_wgt_sum;
			r.deviation_value = (mean > 64'hFFFF) ? 16'hFFFF : mean[15:0];
			r.weights_were_zero = 1'b0;
		end
		means_due.push_back(r);
		mir_wdev_sum = 0;
		mir_wgt_sum = 0;
	endtask

	// Mostly short gaps, a few long ones, none during a burst phase
	function automatic int unsigned pick_gap();
		int unsigned r;
		if ($urandom_range(0, 99) == 0) no_idle_phase = ~no_idle_phase;
		if (no_idle_phase) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	task automatic push_quartet(input int unsigned a, input int unsigned b,
		input logic [1:0] kind, input int unsigned mdev, input int unsigned w,
		input bit lq, input bit lt);
		quartet_t q;
		q.angle_first  = a[14:0];
		q.angle_second = b[14:0];
		q.torsion_kind = kind;
		q.max_dev      = mdev[14:0];
		q.weight       = w[15:0];
		q.last_quartet = lq;
		q.last_torsion = lt;
		quartets_to_send.push_back(q);
	endtask

	function automatic int unsigned rand_angle();
		// mostly in range, sometimes anywhere in the 15-bit field
		return ($urandom_range(0, 15) == 0) ? $urandom_range(0, 32767)
			: $urandom_range(0, TURN - 1);
	endfunction

	// One torsion: filler quartets carry junk parameters, the closing one the real ones
	task automatic push_torsion(input bit lt);
		int unsigned n;
		int unsigned r;
		logic [1:0]  kind;
		int unsigned mdev;
		int unsigned w;
		r = $urandom_range(0, 19);
		n = (r == 0) ? $urandom_range(QMAX + 1, QMAX + 3) : $urandom_range(1, 4);
		kind = 2'($urandom_range(0, 3));
		r = $urandom_range(0, 19);
		mdev = (r == 0) ? 0 : (r == 1) ? $urandom_range(23041, 32767)
			: (r < 8) ? $urandom_range(1, 64) : $urandom_range(1, TURN);
		r = $urandom_range(0, 9);
		w = (r == 0) ? 0 : (r == 1) ? 16'hFFFF : $urandom_range(0, 65535);
		for (int i = 1; i < n; i++)
			push_quartet(rand_angle(), rand_angle(), 2'($urandom_range(0, 3)),
				$urandom_range(0, 32767), $urandom_range(0, 65535), 1'b0,
				1'($urandom_range(0, 1)));
		push_quartet(rand_angle(), rand_angle(), kind, mdev, w, 1'b1, lt);
	endtask

	// Sender: present a new item at the falling edge once the last one went through
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			send_gap    <= 0;
		end else if (!in_ch.valid || in_taken) begin
			if (send_gap > 0) begin
				send_gap    <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (quartets_to_send.size() > 0) begin
				in_ch.data  <= quartets_to_send.pop_front();
				in_ch.valid <= 1'b1;
				send_gap    <= pick_gap();
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: random ready, plus one long hold-off once the run is under way
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			take_gap     <= 0;
			hold_done    <= 1'b0;
			hold_active  <= 1'b0;
			hold_left    <= 0;
		end else if (hold_active) begin
			out_ch.ready <= 1'b0;
			if (hold_left == 0) hold_active <= 1'b0;
			else hold_left <= hold_left - 1;
		end else if (!hold_done && quartets_in >= 300) begin
			hold_done    <= 1'b1;
			hold_active  <= 1'b1;
			hold_left    <= HOLD_CYCLES;
			out_ch.ready <= 1'b0;
		end else if (take_gap > 0) begin
			take_gap     <= take_gap - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			take_gap     <= pick_gap();
		end
	end

	// Input monitor: every accepted item goes through the mirror
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_ch.valid && in_ch.ready;
			if (in_ch.valid && in_ch.ready) begin
				track_quartet(in_ch.data);
				quartets_in <= quartets_in + 1;
			end
		end
	end

	// Output monitor: compare each result with the oldest expected mean
	always @(posedge clk) begin
		tfd_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			means_out <= means_out + 1;
			if (means_due.size() == 0) begin
				if (mismatches < 10)
					$display("ERROR: unexpected result value=%0d zero=%0b",
						out_ch.data.deviation_value, out_ch.data.weights_were_zero);
				mismatches <= mismatches + 1;
			end else begin
				want = means_due.pop_front();
				if (want.weights_were_zero) zero_weight_means <= zero_weight_means + 1;
				if (out_ch.data.deviation_value !== want.deviation_value
					|| out_ch.data.weights_were_zero !== want.weights_were_zero) begin
					if (mismatches < 10)
						$display("ERROR: result %0d expected value=%0d zero=%0b, got value=%0d zero=%0b",
							means_out, want.deviation_value, want.weights_were_zero,
							out_ch.data.deviation_value, out_ch.data.weights_were_zero);
					mismatches <= mismatches + 1;
				end
			end
		end
	end

	// Watchdog: count cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("ERROR: timeout, nothing moved for %0d cycles", quiet_cycles);
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int unsigned nt;
		mir_count = 0;
		mir_ring_first = 0;
		mir_ring_second = 0;
		mir_wdev_sum = 0;
		mir_wgt_sum = 0;
		quartets_in = 0;
		means_out = 0;
		zero_weight_means = 0;
		mismatches = 0;
		quiet_cycles = 0;
		no_idle_phase = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		arst_n = 1'b0;

		// Directed: one torsion per pair unless noted
		// single, angles at the extremes, tightest max_dev, full weight
		push_quartet(0, TURN - 1, tfd_pkg::KIND_SINGLE, 1, 16'hFFFF, 1'b1, 1'b1);
		push_quartet(HALF, 0, tfd_pkg::KIND_SINGLE, TURN, 16'h1000, 1'b1, 1'b1);
		// ring over three quartets
		push_quartet(100, 22000, tfd_pkg::KIND_RING, 1, 0, 1'b0, 1'b0);
		push_quartet(11520, 5, tfd_pkg::KIND_RING, 1, 0, 1'b0, 1'b0);
		push_quartet(23039, 17000, tfd_pkg::KIND_RING, 640, 16'h1000, 1'b1, 1'b1);
		// symmetric: best cross pair wins
		push_quartet(1000, 9000, KIND_SYM, 0, 0, 1'b0, 1'b0);
		push_quartet(7000, 1010, KIND_SYM, 64, 16'h2000, 1'b1, 1'b1);
		// kind three, zero max_dev, angles past a full turn
		push_quartet(32767, 0, KIND_ODD, 0, 16'h0800, 1'b1, 1'b1);
		push_quartet(23040, 32767, tfd_pkg::KIND_SINGLE, 0, 16'hFFFF, 1'b1, 1'b1);
		// last_torsion without last_quartet is ignored, torsion continues
		push_quartet(200, 300, tfd_pkg::KIND_RING, 5, 7, 1'b0, 1'b1);
		push_quartet(400, 500, tfd_pkg::KIND_RING, 90, 16'h1000, 1'b1, 1'b0);
		// zero weight closing the pair opened above, then zero weight mixed with a weighted torsion
		push_quartet(5000, 6000, tfd_pkg::KIND_SINGLE, 100, 0, 1'b1, 1'b1);
		push_quartet(5000, 6000, tfd_pkg::KIND_SINGLE, 100, 0, 1'b1, 1'b0);
		push_quartet(5000, 6000, tfd_pkg::KIND_SINGLE, 100, 16'hFFFF, 1'b1, 1'b1);
		// too many quartets: the tail beyond the store is dropped
		for (int i = 0; i < QMAX + 2; i++)
			push_quartet(i * 2000, 22000 - i * 1500, KIND_SYM, 0, 0, 1'b0, 1'b0);
		push_quartet(3, 3, KIND_SYM, 32767, 16'hFFFF, 1'b1, 1'b1);

		// Random pairs of one to four torsions
		while (quartets_to_send.size() < 1520) begin
			nt = $urandom_range(1, 4);
			for (int t = 0; t < nt; t++) push_torsion(t == nt - 1);
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (quartets_to_send.size() == 0 && !in_ch.valid && means_due.size() == 0);
		repeat (400) @(posedge clk);

		$display("Run covered %0d quartet items and %0d mean results (%0d with zero weight).",
			quartets_in, means_out, zero_weight_means);
		$display("Mismatch count: %0d, results still expected: %0d", mismatches,
			means_due.size());
		if (mismatches == 0 && means_due.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule

### sim.f
sv/tfd_pkg.sv
sv/tfd_if.sv
sv/tfd_ram.sv
sv/tfd_div.sv
sv/tfd_ctrl.sv
sv/tfd_dp.sv
sv/torsion_fingerprint_deviation.sv
sim/torsion_fingerprint_deviation_tb.sv
